// ----- hw/rtl/brd_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded draw package
// Shared widths, generator constants, sequencer states and the rotate helper
// for the bounded uniform draw core.
// ----------------------------------------------------------------------------
`default_nettype none

package brd_pkg;

  // Widths of the generator word and of the draw bound.
  localparam int WORD_W  = 64;
  localparam int BOUND_W = 31;
  localparam int HALF_W  = WORD_W / 2;
  localparam int CNT_W   = $clog2(WORD_W);

  // Seed expansion constants.
  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam int MIX_SH_1 = 30;
  localparam int MIX_SH_2 = 27;
  localparam int MIX_SH_3 = 31;

  // Generator step constants.
  localparam int ROT_SUM  = 23;
  localparam int SHL_W1   = 17;
  localparam int ROT_W3   = 45;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_SEED_MUL,
    ST_SEED_MIX,
    ST_THRESH_DIV,
    ST_GEN_SUM,
    ST_GEN_UPD,
    ST_GEN_CHK,
    ST_DRAW_DIV,
    ST_DONE
  } state_t;

  // Rotate a generator word left by a constant amount.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                            input int unsigned amt);
    return (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_uniform_random_draw_core.sv -----
// A draw runs the threshold division, then generator steps (sum, update, check;
// one more step per rejected output), then the final remainder division, and
// then loads the result register; the next item is taken once the core is idle.
// A zero bound goes straight to completion; a reseed holds in_stall until all four state words are written.
// One item is in work at a time; a stalled result holds the core in completion.
// After reset the block expands seed zero and holds in_stall meanwhile.
// ----------------------------------------------------------------------------
// Bounded uniform random draw core
// 256-bit xoshiro256++ generator seeded by SplitMix64, with an unbiased
// bounded draw built from a radix-2 divider; seeding uses one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_uniform_random_draw_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_op,
  input  wire logic [brd_pkg::WORD_W-1:0]  in_seed,
  input  wire logic [brd_pkg::BOUND_W-1:0] in_bound,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [brd_pkg::BOUND_W-1:0] out_value
);

  localparam int W  = brd_pkg::WORD_W;
  localparam int BW = brd_pkg::BOUND_W;
  localparam int HW = brd_pkg::HALF_W;
  localparam int CW = brd_pkg::CNT_W;

  brd_pkg::state_t state_r, state_nxt;

  logic [1:0]    idx_r, idx_nxt;
  logic [W-1:0]  ctr_r, ctr_nxt;
  logic [W-1:0]  mulx_r, mulx_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          sel_r, sel_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [W-1:0]  s_r [4];
  logic [W-1:0]  s_nxt [4];
  logic [W-1:0]  sum_r, sum_nxt;
  logic [W-1:0]  draw_r, draw_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] bound_r, bound_nxt;
  logic [BW-1:0] thresh_r, thresh_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_value_r, out_value_nxt;

  logic          in_fire;
  logic [W-1:0]  mul_k;
  logic [HW-1:0] mul_a, mul_b;
  logic [W-1:0]  mul_p;
  logic [BW:0]   div_try;
  logic [BW-1:0] rem_step;
  logic [W-1:0]  gen_res;
  logic [W-1:0]  gen_shl;
  logic [W-1:0]  n0, n1, n2, n3;
  logic [W-1:0]  ctr_add;
  logic [W-1:0]  mix_z;

  assign in_stall  = (state_r != brd_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Shared multiplier: three 32x32 partial products give the low product word.
  always_comb begin
    mul_k = sel_r ? brd_pkg::MIX_MUL_B : brd_pkg::MIX_MUL_A;
    case (phase_r)
      2'd0: begin
        mul_a = mulx_r[HW-1:0];
        mul_b = mul_k[HW-1:0];
      end
      2'd1: begin
        mul_a = mulx_r[W-1:HW];
        mul_b = mul_k[HW-1:0];
      end
      default: begin
        mul_a = mulx_r[HW-1:0];
        mul_b = mul_k[W-1:HW];
      end
    endcase
    mul_p = W'(mul_a) * W'(mul_b);
  end

  // Radix-2 restoring remainder step, shared by both divisions.
  always_comb begin
    div_try  = {rem_r, div_r[W-1]};
    rem_step = (div_try >= {1'b0, bound_r}) ? BW'(div_try - {1'b0, bound_r})
                                            : div_try[BW-1:0];
  end

  // One xoshiro256++ step from the stored words and the registered sum.
  always_comb begin
    gen_res = brd_pkg::rotl(sum_r, brd_pkg::ROT_SUM) + s_r[0];
    gen_shl = s_r[1] << brd_pkg::SHL_W1;
    n2      = s_r[2] ^ s_r[0];
    n3      = s_r[3] ^ s_r[1];
    n1      = s_r[1] ^ n2;
    n0      = s_r[0] ^ n3;
  end

  assign ctr_add = ctr_r + brd_pkg::GOLDEN_STEP;
  assign mix_z   = sel_r ? (acc_r ^ (acc_r >> brd_pkg::MIX_SH_3))
                         : (acc_r ^ (acc_r >> brd_pkg::MIX_SH_2));

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ctr_nxt       = ctr_r;
    mulx_nxt      = mulx_r;
    acc_nxt       = acc_r;
    sel_nxt       = sel_r;
    phase_nxt     = phase_r;
    for (int i = 0; i < 4; i++) begin
      s_nxt[i] = s_r[i];
    end
    sum_nxt       = sum_r;
    draw_nxt      = draw_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    bound_nxt     = bound_r;
    thresh_nxt    = thresh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    case (state_r)
      brd_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!in_op) begin
            ctr_nxt   = in_seed;
            idx_nxt   = 2'd0;
            state_nxt = brd_pkg::ST_SEED_ADD;
          end else if (in_bound == '0) begin
            bound_nxt = in_bound;
            rem_nxt   = '0;
            state_nxt = brd_pkg::ST_DONE;
          end else begin
            bound_nxt = in_bound;
            div_nxt   = {W{1'b0}} - {{(W-BW){1'b0}}, in_bound};
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = brd_pkg::ST_THRESH_DIV;
          end
        end
      end

      // Advance the seed counter and apply the first xor-shift.
      brd_pkg::ST_SEED_ADD: begin
        ctr_nxt   = ctr_add;
        mulx_nxt  = ctr_add ^ (ctr_add >> brd_pkg::MIX_SH_1);
        sel_nxt   = 1'b0;
        phase_nxt = 2'd0;
        state_nxt = brd_pkg::ST_SEED_MUL;
      end

      // Accumulate the three partial products into the low product word.
      brd_pkg::ST_SEED_MUL: begin
        if (phase_r == 2'd0) begin
          acc_nxt = mul_p;
        end else begin
          acc_nxt = {acc_r[W-1:HW] + mul_p[HW-1:0], acc_r[HW-1:0]};
        end
        if (phase_r == 2'd2) begin
          phase_nxt = 2'd0;
          state_nxt = brd_pkg::ST_SEED_MIX;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end

      // Xor-shift after each multiply; the second one yields a state word.
      brd_pkg::ST_SEED_MIX: begin
        if (!sel_r) begin
          mulx_nxt  = mix_z;
          sel_nxt   = 1'b1;
          state_nxt = brd_pkg::ST_SEED_MUL;
        end else begin
          s_nxt[idx_r] = mix_z;
          idx_nxt      = idx_r + 2'd1;
          state_nxt    = (idx_r == 2'd3) ? brd_pkg::ST_IDLE : brd_pkg::ST_SEED_ADD;
        end
      end

      // Threshold is the remainder of 2^64 minus the bound.
      brd_pkg::ST_THRESH_DIV: begin
        rem_nxt = rem_step;
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(W-1)) begin
          thresh_nxt = rem_step;
          state_nxt  = brd_pkg::ST_GEN_SUM;
        end
      end

      brd_pkg::ST_GEN_SUM: begin
        sum_nxt   = s_r[0] + s_r[3];
        state_nxt = brd_pkg::ST_GEN_UPD;
      end

      brd_pkg::ST_GEN_UPD: begin
        draw_nxt  = gen_res;
        s_nxt[0]  = n0;
        s_nxt[1]  = n1;
        s_nxt[2]  = n2 ^ gen_shl;
        s_nxt[3]  = brd_pkg::rotl(n3, brd_pkg::ROT_W3);
        state_nxt = brd_pkg::ST_GEN_CHK;
      end

      // Reject outputs below the threshold, else reduce modulo the bound.
      brd_pkg::ST_GEN_CHK: begin
        if (draw_r < {{(W-BW){1'b0}}, thresh_r}) begin
          state_nxt = brd_pkg::ST_GEN_SUM;
        end else begin
          div_nxt   = draw_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = brd_pkg::ST_DRAW_DIV;
        end
      end

      brd_pkg::ST_DRAW_DIV: begin
        rem_nxt = rem_step;
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(W-1)) begin
          state_nxt = brd_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      brd_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rem_r;
          state_nxt     = brd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = brd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the expansion of seed zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brd_pkg::ST_SEED_ADD;
      idx_r       <= 2'd0;
      ctr_r       <= '0;
      sel_r       <= 1'b0;
      phase_r     <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ctr_r       <= ctr_nxt;
      sel_r       <= sel_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mulx_r      <= mulx_nxt;
    acc_r       <= acc_nxt;
    for (int i = 0; i < 4; i++) begin
      s_r[i] <= s_nxt[i];
    end
    sum_r       <= sum_nxt;
    draw_r      <= draw_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    bound_r     <= bound_nxt;
    thresh_r    <= thresh_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTHESIS
  // A new result beat only ever comes from the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == brd_pkg::ST_DONE))
    else $error("result beat raised outside completion");

  // A finished draw always lies below its bound, or is zero for a zero bound.
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brd_pkg::ST_DONE) |-> ((rem_r < bound_r) || (rem_r == '0)))
    else $error("draw result out of range");

  // The bit counter is back at zero whenever the block waits for an item.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brd_pkg::ST_IDLE) |-> (cnt_r == '0))
    else $error("divider counter not cleared when idle");
`endif

endmodule

`default_nettype wire
